[sv/kwdt_pkg.sv]
// types and constants shared by the keyed watchdog timer
`timescale 1ns / 1ps

package kwdt_pkg;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_UNLOCK    = 3'd1,
        ACT_REFRESH   = 3'd2,
        ACT_CONTROL   = 3'd3,
        ACT_TIMEOUT_H = 3'd4,
        ACT_TIMEOUT_L = 3'd5,
        ACT_PRESCALER = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        PH_LOCKED   = 2'd0,
        PH_FIRST    = 2'd1,
        PH_UNLOCKED = 2'd2
    } phase_t;

    localparam logic [15:0] KEY_UNLOCK_A  = 16'hC520;
    localparam logic [15:0] KEY_UNLOCK_B  = 16'hD928;
    localparam logic [15:0] KEY_REFRESH_A = 16'hA602;
    localparam logic [15:0] KEY_REFRESH_B = 16'hB480;

    localparam logic [9:0]  WINDOW_RESET   = 10'd256;
    localparam logic [31:0] TIMEOUT_RESET  = 32'h004C_4B4C;
    localparam logic [2:0]  DIVIDE_RESET   = 3'd4;

    localparam logic [1:0]  REG_UNLOCK_WINDOW = 2'd0;

endpackage

[sv/keyed_watchdog_timer_unit.sv]
// keyed watchdog timer: key-gated configuration, prescaled counter, timeout flag
// an accepted input transfer's result is registered and offered as a result transfer in the next cycle
// throughput: one item per cycle unless stalled; output reg is refilled in the cycle taken
// in_ready stays high while the output register is empty or being taken
// reset: asynchronous, active low; locked, enabled, timeout 0x004C4B4C, prescaler 4
// unlock_window resets to 256; user must write via apb port only while idle, unenforced
`timescale 1ns / 1ps

module keyed_watchdog_timer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [15:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        dog_enabled,
    output logic        is_unlocked,
    output logic        timeout_reset,
    output logic        bad_sequence,
    output logic [31:0] count_now,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [9:0]        window_cfg_reg;
    kwdt_pkg::phase_t  phase_reg, phase_next;
    logic [9:0]        window_left_reg, window_left_next;
    logic              refresh_half_reg, refresh_half_next;
    logic              enable_reg, enable_next;
    logic              update_allowed_reg, update_allowed_next;
    logic [31:0]       timeout_reg, timeout_next;
    logic [2:0]        divide_setting_reg, divide_setting_next;
    logic [2:0]        divide_count_reg, divide_count_next;
    logic [31:0]       dog_count_reg, dog_count_next;

    logic              out_valid_reg;
    logic              fired_reg, fired_next;
    logic              bad_reg, bad_next;

    logic              accept;
    logic              is_open;
    logic              is_tick;
    logic              cfg_write;
    logic [31:0]       count_inc;

    // apb configuration

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr == kwdt_pkg::REG_UNLOCK_WINDOW) ? {22'd0, window_cfg_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_cfg_reg <= kwdt_pkg::WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            window_cfg_reg <= pwdata[9:0];
        end
    end

    // handshake

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_open  = (phase_reg == kwdt_pkg::PH_UNLOCKED);
    assign is_tick  = (action == kwdt_pkg::ACT_TICK);

    // unlock sequence

    always_comb
    begin
        phase_next       = phase_reg;
        window_left_next = window_left_reg;
        if (action == kwdt_pkg::ACT_UNLOCK)
        begin
            priority if (write_data == kwdt_pkg::KEY_UNLOCK_A)
            begin
                phase_next       = kwdt_pkg::PH_FIRST;
                window_left_next = 10'd0;
            end
            else if (write_data == kwdt_pkg::KEY_UNLOCK_B && phase_reg == kwdt_pkg::PH_FIRST)
            begin
                phase_next       = kwdt_pkg::PH_UNLOCKED;
                window_left_next = window_cfg_reg;
            end
            else
            begin
                phase_next       = kwdt_pkg::PH_LOCKED;
                window_left_next = 10'd0;
            end
        end
        else if (is_tick && is_open)
        begin
            if (window_left_reg <= 10'd1)
            begin
                phase_next       = kwdt_pkg::PH_LOCKED;
                window_left_next = 10'd0;
            end
            else
            begin
                window_left_next = window_left_reg - 10'd1;
            end
        end
    end

    // item datapath

    assign count_inc = dog_count_reg + 32'd1;

    always_comb
    begin
        refresh_half_next   = refresh_half_reg;
        enable_next         = enable_reg;
        update_allowed_next = update_allowed_reg;
        timeout_next        = timeout_reg;
        divide_setting_next = divide_setting_reg;
        divide_count_next   = divide_count_reg;
        dog_count_next      = dog_count_reg;
        fired_next          = 1'b0;
        bad_next            = 1'b0;
        unique case (action)
            kwdt_pkg::ACT_TICK:
            begin
                if (enable_reg)
                begin
                    if (divide_count_reg >= divide_setting_reg)
                    begin
                        divide_count_next = 3'd0;
                        if (count_inc >= timeout_reg)
                        begin
                            dog_count_next = 32'd0;
                            fired_next     = 1'b1;
                        end
                        else
                        begin
                            dog_count_next = count_inc;
                        end
                    end
                    else
                    begin
                        divide_count_next = divide_count_reg + 3'd1;
                    end
                end
            end
            kwdt_pkg::ACT_UNLOCK:
            begin
                bad_next = (write_data != kwdt_pkg::KEY_UNLOCK_A)
                        && !(write_data == kwdt_pkg::KEY_UNLOCK_B
                             && phase_reg == kwdt_pkg::PH_FIRST);
            end
            kwdt_pkg::ACT_REFRESH:
            begin
                priority if (write_data == kwdt_pkg::KEY_REFRESH_A)
                begin
                    refresh_half_next = 1'b1;
                end
                else if (write_data == kwdt_pkg::KEY_REFRESH_B && refresh_half_reg)
                begin
                    dog_count_next    = 32'd0;
                    divide_count_next = 3'd0;
                    refresh_half_next = 1'b0;
                end
                else
                begin
                    refresh_half_next = 1'b0;
                    bad_next          = 1'b1;
                end
            end
            kwdt_pkg::ACT_CONTROL:
            begin
                if (is_open && update_allowed_reg)
                begin
                    enable_next         = write_data[0];
                    update_allowed_next = write_data[1];
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
            kwdt_pkg::ACT_TIMEOUT_H:
            begin
                if (is_open)
                    timeout_next = {write_data, timeout_reg[15:0]};
                else
                    bad_next = 1'b1;
            end
            kwdt_pkg::ACT_TIMEOUT_L:
            begin
                if (is_open)
                    timeout_next = {timeout_reg[31:16], write_data};
                else
                    bad_next = 1'b1;
            end
            kwdt_pkg::ACT_PRESCALER:
            begin
                if (is_open)
                    divide_setting_next = write_data[2:0];
                else
                    bad_next = 1'b1;
            end
            default:
            begin
                bad_next = 1'b0;
            end
        endcase
    end

    // state and result registers

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= kwdt_pkg::PH_LOCKED;
            window_left_reg    <= 10'd0;
            refresh_half_reg   <= 1'b0;
            enable_reg         <= 1'b1;
            update_allowed_reg <= 1'b1;
            timeout_reg        <= kwdt_pkg::TIMEOUT_RESET;
            divide_setting_reg <= kwdt_pkg::DIVIDE_RESET;
            divide_count_reg   <= 3'd0;
            dog_count_reg      <= 32'd0;
            out_valid_reg      <= 1'b0;
            fired_reg          <= 1'b0;
            bad_reg            <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg          <= phase_next;
                window_left_reg    <= window_left_next;
                refresh_half_reg   <= refresh_half_next;
                enable_reg         <= enable_next;
                update_allowed_reg <= update_allowed_next;
                timeout_reg        <= timeout_next;
                divide_setting_reg <= divide_setting_next;
                divide_count_reg   <= divide_count_next;
                dog_count_reg      <= dog_count_next;
                fired_reg          <= fired_next;
                bad_reg            <= bad_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign dog_enabled   = enable_reg;
    assign is_unlocked   = (phase_reg == kwdt_pkg::PH_UNLOCKED);
    assign timeout_reset = fired_reg;
    assign bad_sequence  = bad_reg;
    assign count_now     = dog_count_reg;

    // assertions

    a_window_closed_when_locked: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != kwdt_pkg::PH_UNLOCKED |-> window_left_reg == 10'd0)
        else $error("window count left over while locked");

    a_fire_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && fired_reg |-> dog_count_reg == 32'd0)
        else $error("timeout fired with nonzero count");

    a_fire_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(fired_reg && bad_reg))
        else $error("timeout and bad sequence on one transfer");

    a_prescale_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_tick && enable_reg |=> divide_count_reg <= divide_setting_reg
            || $past(divide_count_reg) > $past(divide_setting_reg))
        else $error("prescale count ran past setting");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(count_now)
            && $stable(bad_sequence) && $stable(timeout_reset))
        else $error("stalled result changed");

endmodule
